// File: sv/dbcs_to_unicode_converter_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef DBCS_TO_UNICODE_CONVERTER_ASSERT_SVH
`define DBCS_TO_UNICODE_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DBCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbcs same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define DBCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbcs next-cycle check failed");

`endif

// File: sv/dbcs_pkg.sv
// Shared constants, codes and types of the double-byte to Unicode converter.
package dbcs_pkg;

  localparam int unsigned RANGE_SLOTS = 32;
  localparam int unsigned CODE_DEPTH  = 32768;
  localparam int unsigned CODE_AW     = $clog2(CODE_DEPTH);

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned ADDR_W = 15;

  localparam logic [CHAR_W-1:0] NO_CODE    = 16'hFFFF;
  localparam logic [POS_W-1:0]  CODE_LIMIT = POS_W'(CODE_DEPTH);

  // Request kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_CONVERT = 2'd0,
    KIND_LEAD    = 2'd1,
    KIND_RANGE   = 2'd2,
    KIND_CODE    = 2'd3
  } kind_e;

  // One range descriptor.
  typedef struct packed {
    logic [CHAR_W-1:0] low;
    logic [CHAR_W-1:0] high;
    logic [CHAR_W-1:0] base;
  } range_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [CHAR_W-1:0] ch;
    logic [CNT_W-1:0]  remain;
    logic [POS_W-1:0]  pos;
  } token_t;

endpackage

// File: sv/dbcs_range_cell.sv
// One range cell: holds a descriptor and tests the passing search token.
module dbcs_range_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  dbcs_pkg::range_t wr_range_i,
  input  dbcs_pkg::token_t tok_i,
  output dbcs_pkg::token_t tok_o
);
  import dbcs_pkg::*;

  range_t rng_q;
  token_t tok_q, tok_d;
  logic   in_range;
  logic   match;

  // Descriptor storage, written only by range load requests.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rng_q <= wr_range_i;
    end
  end

  // Match test; the first active cell that matches claims the token.
  always_comb begin
    in_range = (tok_i.ch >= rng_q.low) && (tok_i.ch <= rng_q.high);
    match    = tok_i.valid && !tok_i.found && (tok_i.remain != '0) && in_range;
    tok_d    = tok_i;
    if (tok_i.remain != '0) begin
      tok_d.remain = tok_i.remain - CNT_W'(1);
    end
    if (match) begin
      tok_d.found = 1'b1;
      tok_d.pos   = POS_W'(rng_q.base) + POS_W'(tok_i.ch - rng_q.low);
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/dbcs_code_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dbcs_code_ram #(
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/dbcs_to_unicode_converter.sv
// Top level of the double-byte character set to Unicode converter.
// A converted character walks a row of RANGE_SLOTS range cells, each of which
// registers the search token, then reads the code RAM and lands in the output
// register; the next request is taken once the result has entered the output
// register. A held lead byte and every load request leave the block free for
// the next request; a dangling lead byte skips the range cells and the code
// RAM, and holds the block until its result has entered the output register.
// A result still waiting in the output register under a low m_axis_tready
// delays the next one and with it the next request. The lead map is a
// reset-cleared flop array, so no clearing pass follows reset. s_axis_tuser
// selects the request kind and s_axis_tlast marks the last byte of a string;
// m_axis_tuser carries the unmapped and dangling flags.
module dbcs_to_unicode_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: range_count
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [22:8] write_addr, [23] lead_mark, [39:24] range_low,
  // [55:40] range_high, [71:56] range_base, [87:72] entry_value
  input  logic [87:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] unicode_code
  output logic [15:0] m_axis_tdata,
  // [0] unmapped, [1] dangling_lead
  output logic [1:0]  m_axis_tuser
);
  import dbcs_pkg::*;

  // Request fields.
  kind_e              kind;
  logic [7:0]         data_byte;
  logic [ADDR_W-1:0]  write_addr;
  logic               lead_mark;
  range_t             wr_range;
  logic [CHAR_W-1:0]  entry_value;
  logic               req_acc;

  assign kind        = kind_e'(s_axis_tuser);
  assign data_byte   = s_axis_tdata[7:0];
  assign write_addr  = s_axis_tdata[22:8];
  assign lead_mark   = s_axis_tdata[23];
  assign wr_range    = '{low: s_axis_tdata[39:24], high: s_axis_tdata[55:40],
                         base: s_axis_tdata[71:56]};
  assign entry_value = s_axis_tdata[87:72];

  // Control state.
  logic [CNT_W-1:0] range_count_q;
  logic [255:0]     lead_map_q;
  logic             pending_q, pending_d;
  logic [7:0]       held_q, held_d;
  logic             busy_q, busy_d;
  logic             fin_valid_q, fin_valid_d;
  logic             fin_ram_q, fin_ram_d;
  logic             fin_unm_q, fin_unm_d;
  logic             fin_dang_q, fin_dang_d;
  logic             out_valid_q;
  logic [CHAR_W-1:0] out_code_q;
  logic             out_unm_q;
  logic             out_dang_q;
  logic             out_load;

  token_t             chain [RANGE_SLOTS+1];
  token_t             launch;
  token_t             tail;
  logic [RANGE_SLOTS-1:0] cell_we;
  logic               is_lead;
  logic               ram_we;
  logic               ram_re;
  logic [POS_W-1:0]   waddr_ext;
  logic [CHAR_W-1:0]  ram_rdata;

  assign s_axis_tready = !busy_q;
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign is_lead       = lead_map_q[data_byte];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_count_q <= '0;
    end else if (cfg_we_i) begin
      range_count_q <= cfg_wdata_i;
    end
  end

  // Lead map, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_map_q <= '0;
    end else if (req_acc && kind == KIND_LEAD) begin
      lead_map_q[data_byte] <= lead_mark;
    end
  end

  // Byte decode: launch a search, hold a lead, or flag a dangling lead.
  always_comb begin
    pending_d   = pending_q;
    held_d      = held_q;
    launch      = '0;
    fin_valid_d = fin_valid_q;
    fin_ram_d   = fin_ram_q;
    fin_unm_d   = fin_unm_q;
    fin_dang_d  = fin_dang_q;
    busy_d      = busy_q;
    if (out_load) begin
      fin_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
    if (req_acc && kind == KIND_CONVERT) begin
      launch.remain = range_count_q;
      if (pending_q) begin
        pending_d    = 1'b0;
        launch.valid = 1'b1;
        launch.ch    = {held_q, data_byte};
        busy_d       = 1'b1;
      end else if (is_lead && s_axis_tlast) begin
        fin_valid_d = 1'b1;
        fin_ram_d   = 1'b0;
        fin_unm_d   = 1'b0;
        fin_dang_d  = 1'b1;
        busy_d      = 1'b1;
      end else if (is_lead) begin
        pending_d = 1'b1;
        held_d    = data_byte;
      end else begin
        launch.valid = 1'b1;
        launch.ch    = {8'h00, data_byte};
        busy_d       = 1'b1;
      end
    end
    // Search finished: issue the code read or mark unmapped.
    if (tail.valid) begin
      fin_valid_d = 1'b1;
      fin_ram_d   = ram_re;
      fin_unm_d   = !ram_re;
      fin_dang_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      held_q      <= '0;
      busy_q      <= 1'b0;
      fin_valid_q <= 1'b0;
      fin_ram_q   <= 1'b0;
      fin_unm_q   <= 1'b0;
      fin_dang_q  <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      held_q      <= held_d;
      busy_q      <= busy_d;
      fin_valid_q <= fin_valid_d;
      fin_ram_q   <= fin_ram_d;
      fin_unm_q   <= fin_unm_d;
      fin_dang_q  <= fin_dang_d;
    end
  end

  // Row of range cells.
  assign chain[0] = launch;

  for (genvar i = 0; i < RANGE_SLOTS; i++) begin : g_cell
    assign cell_we[i] = req_acc && (kind == KIND_RANGE) && (write_addr == ADDR_W'(i));

    dbcs_range_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (cell_we[i]),
      .wr_range_i (wr_range),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1])
    );
  end

  assign tail = chain[RANGE_SLOTS];

  // Code table.
  assign waddr_ext = POS_W'(write_addr);
  assign ram_we    = req_acc && (kind == KIND_CODE) && (waddr_ext < CODE_LIMIT);
  assign ram_re    = tail.valid && tail.found && (tail.pos < CODE_LIMIT);

  dbcs_code_ram #(
    .ADDR_W (CODE_AW),
    .DATA_W (CHAR_W)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr_ext[CODE_AW-1:0]),
    .wdata_i (entry_value),
    .re_i    (ram_re),
    .raddr_i (tail.pos[CODE_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Output register.
  assign out_load = fin_valid_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_code_q <= fin_ram_q ? ram_rdata : NO_CODE;
      out_unm_q  <= fin_unm_q;
      out_dang_q <= fin_dang_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = {out_dang_q, out_unm_q};

  // Checks.
`include "dbcs_to_unicode_converter_assert.svh"

  `DBCS_ASSERT_NOW(a_tail_busy, clk_i, rst_ni, tail.valid, busy_q && !fin_valid_q)
  `DBCS_ASSERT_NEXT(a_load_frees, clk_i, rst_ni, out_load, !fin_valid_q && !busy_q)
  `DBCS_ASSERT_NOW(a_flags_excl, clk_i, rst_ni, m_axis_tvalid, !(out_unm_q && out_dang_q))
  `DBCS_ASSERT_NOW(a_flag_code, clk_i, rst_ni, m_axis_tvalid && (out_unm_q || out_dang_q),
                   out_code_q == NO_CODE)

endmodule
